// ===== rtl/lav_pkg.sv =====
// Shared types and constants for the look-at view matrix block.
// Used by lav_div, lav_norm, lav_ser and lookat_view_matrix; depends on nothing else.
package lav_pkg;

    // Default fraction width of the Q format.
    localparam int LAV_FRAC_BITS = 16;

    // Width of a magnitude after the normalizing shift, top bit at 2^29.
    localparam int LAV_NORM_W = 30;

    // Row number of the final (translation) row.
    localparam logic [1:0] LAV_LAST_ROW = 2'd3;

    // One request: camera position, look target and world up vector.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } lav_req_t;

    // One result row of the view matrix.
    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
        logic signed [31:0] third_value;
        logic               degenerate;
        logic               last_row;
    } lav_res_t;

    // A finished matrix handed to the row serializer: rows[row][column].
    typedef struct packed {
        logic [3:0][2:0][31:0] rows;
        logic                  degenerate;
    } lav_mat_t;

endpackage

// ===== rtl/lav_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Standalone; carries a sideband word of SIDE_W bits alongside each value.
module lav_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [61:0]       in_sum,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int STAGES = 32;

    logic              v_reg    [STAGES];
    logic [63:0]       x_reg    [STAGES];
    logic [63:0]       r_reg    [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];

    generate
        for (genvar k = 0; k < STAGES; k++) begin : g_stage
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);

            logic              v_in;
            logic [63:0]       x_in;
            logic [63:0]       r_in;
            logic [SIDE_W-1:0] s_in;
            logic [63:0]       trial;
            logic [63:0]       x_next;
            logic [63:0]       r_next;

            if (k == 0) begin : g_first
                assign v_in = in_valid;
                assign x_in = {2'b00, in_sum};
                assign r_in = '0;
                assign s_in = in_side;
            end
            else begin : g_rest
                assign v_in = v_reg[k-1];
                assign x_in = x_reg[k-1];
                assign r_in = r_reg[k-1];
                assign s_in = side_reg[k-1];
            end

            // One step of the digit-by-digit root: try the current bit.
            always_comb
            begin
                trial = r_in + BIT;
                if (x_in >= trial)
                begin
                    x_next = x_in - trial;
                    r_next = (r_in >> 1) + BIT;
                end
                else
                begin
                    x_next = x_in;
                    r_next = r_in >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k]    <= x_next;
                    r_reg[k]    <= r_next;
                    side_reg[k] <= s_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[STAGES-1];
    assign out_root  = r_reg[STAGES-1][31:0];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== rtl/lav_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor.
// Depends on lav_pkg for the normalized magnitude width.
module lav_div
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = LAV_FRAC_BITS,
    parameter int SIDE_W    = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [31:0]                      in_len,
    input  logic [2:0][LAV_NORM_W-1:0]       in_num,
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic [2:0][FRAC_BITS:0]          out_q,
    output logic [SIDE_W-1:0]                out_side
);

    localparam int QW   = FRAC_BITS + 1;
    localparam int CMPW = LAV_NORM_W + FRAC_BITS + 2;

    logic                     v_reg    [QW];
    logic [31:0]              len_reg  [QW];
    logic [2:0][CMPW-1:0]     rem_reg  [QW];
    logic [2:0][QW-1:0]       q_reg    [QW];
    logic [SIDE_W-1:0]        side_reg [QW];

    generate
        for (genvar k = 0; k < QW; k++) begin : g_stage
            localparam int SH = QW - 1 - k;

            logic                 v_in;
            logic [31:0]          len_in;
            logic [2:0][CMPW-1:0] rem_in;
            logic [2:0][QW-1:0]   q_in;
            logic [SIDE_W-1:0]    s_in;
            logic [CMPW-1:0]      dv;
            logic [2:0][CMPW-1:0] rem_next;
            logic [2:0][QW-1:0]   q_next;

            if (k == 0) begin : g_first
                assign v_in   = in_valid;
                assign len_in = in_len;
                assign q_in   = '0;
                assign s_in   = in_side;
                for (genvar l = 0; l < 3; l++) begin : g_lane
                    assign rem_in[l] = CMPW'(in_num[l]) << FRAC_BITS;
                end
            end
            else begin : g_rest
                assign v_in   = v_reg[k-1];
                assign len_in = len_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign s_in   = side_reg[k-1];
            end

            // Decide one quotient bit in each lane.
            always_comb
            begin
                dv       = CMPW'(len_in) << SH;
                rem_next = rem_in;
                q_next   = q_in;
                for (int l = 0; l < 3; l++)
                begin
                    if (rem_in[l] >= dv)
                    begin
                        rem_next[l]    = rem_in[l] - dv;
                        q_next[l][SH]  = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    len_reg[k]  <= len_in;
                    rem_reg[k]  <= rem_next;
                    q_reg[k]    <= q_next;
                    side_reg[k] <= s_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ===== rtl/lav_norm.sv =====
// Fixed-point vector normalizer: magnitude, shift, square sum, root, divide.
// Depends on lav_pkg, lav_isqrt and lav_div.
module lav_norm
    import lav_pkg::*;
#(
    parameter int IW        = 33,
    parameter int SIDE_W    = 1,
    parameter int FRAC_BITS = LAV_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [2:0][IW-1:0]        in_vec,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic [2:0][FRAC_BITS+1:0] out_vec,
    output logic                      out_ok,
    output logic [SIDE_W-1:0]         out_side
);

    localparam int NW     = LAV_NORM_W;
    localparam int CW     = FRAC_BITS + 2;
    localparam int QW     = FRAC_BITS + 1;
    localparam int PW     = $clog2(IW);
    localparam int SQ_SW  = SIDE_W + 3 * NW + 4;
    localparam int DV_SW  = SIDE_W + 4;
    localparam logic [PW-1:0] TOP_BIT = PW'(NW - 1);

    // Stage 1: sign and magnitude of each component, and the largest one.
    logic               s1_valid_reg;
    logic [2:0][IW-1:0] s1_mag_reg;
    logic [2:0]         s1_neg_reg;
    logic [IW-1:0]      s1_mx_reg;
    logic [SIDE_W-1:0]  s1_side_reg;
    logic [2:0][IW-1:0] s1_mag_next;
    logic [2:0]         s1_neg_next;
    logic [IW-1:0]      s1_mx_next;

    always_comb
    begin
        s1_mx_next = '0;
        for (int l = 0; l < 3; l++)
        begin
            s1_neg_next[l] = in_vec[l][IW-1];
            s1_mag_next[l] = s1_neg_next[l] ? (~in_vec[l] + 1'b1) : in_vec[l];
            if (s1_mag_next[l] > s1_mx_next)
                s1_mx_next = s1_mag_next[l];
        end
    end

    // Stage 2: position of the leading one of the largest magnitude.
    logic               s2_valid_reg;
    logic [2:0][IW-1:0] s2_mag_reg;
    logic [2:0]         s2_neg_reg;
    logic [PW-1:0]      s2_msb_reg;
    logic               s2_nz_reg;
    logic [SIDE_W-1:0]  s2_side_reg;
    logic [PW-1:0]      s2_msb_next;

    always_comb
    begin
        s2_msb_next = '0;
        for (int b = 0; b < IW; b++)
        begin
            if (s1_mx_reg[b])
                s2_msb_next = PW'(b);
        end
    end

    // Stage 3: shift all magnitudes together so the top bit sits at 2^29.
    logic               s3_valid_reg;
    logic [2:0][NW-1:0] s3_nm_reg;
    logic [2:0]         s3_neg_reg;
    logic               s3_nz_reg;
    logic [SIDE_W-1:0]  s3_side_reg;
    logic [2:0][NW-1:0] s3_nm_next;
    logic [IW-1:0]      shifted;

    always_comb
    begin
        shifted = '0;
        for (int l = 0; l < 3; l++)
        begin
            if (s2_msb_reg > TOP_BIT)
                shifted = s2_mag_reg[l] >> (s2_msb_reg - TOP_BIT);
            else
                shifted = s2_mag_reg[l] << (TOP_BIT - s2_msb_reg);
            s3_nm_next[l] = shifted[NW-1:0];
        end
    end

    // Stage 4: squares. Stage 5: their sum.
    logic                 s4_valid_reg;
    logic [2:0][2*NW-1:0] s4_sq_reg;
    logic [2:0][NW-1:0]   s4_nm_reg;
    logic [2:0]           s4_neg_reg;
    logic                 s4_nz_reg;
    logic [SIDE_W-1:0]    s4_side_reg;

    logic                 s5_valid_reg;
    logic [2*NW+1:0]      s5_sum_reg;
    logic [2:0][NW-1:0]   s5_nm_reg;
    logic [2:0]           s5_neg_reg;
    logic                 s5_nz_reg;
    logic [SIDE_W-1:0]    s5_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg  <= s1_mag_next;
            s1_neg_reg  <= s1_neg_next;
            s1_mx_reg   <= s1_mx_next;
            s1_side_reg <= in_side;

            s2_mag_reg  <= s1_mag_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_msb_reg  <= s2_msb_next;
            s2_nz_reg   <= |s1_mx_reg;
            s2_side_reg <= s1_side_reg;

            s3_nm_reg   <= s3_nm_next;
            s3_neg_reg  <= s2_neg_reg;
            s3_nz_reg   <= s2_nz_reg;
            s3_side_reg <= s2_side_reg;

            for (int l = 0; l < 3; l++)
                s4_sq_reg[l] <= (2*NW)'(s3_nm_reg[l]) * (2*NW)'(s3_nm_reg[l]);
            s4_nm_reg   <= s3_nm_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_nz_reg   <= s3_nz_reg;
            s4_side_reg <= s3_side_reg;

            s5_sum_reg  <= (2*NW+2)'(s4_sq_reg[0]) + (2*NW+2)'(s4_sq_reg[1])
                         + (2*NW+2)'(s4_sq_reg[2]);
            s5_nm_reg   <= s4_nm_reg;
            s5_neg_reg  <= s4_neg_reg;
            s5_nz_reg   <= s4_nz_reg;
            s5_side_reg <= s4_side_reg;
        end
    end

    // Square root of the sum gives the vector length.
    logic               sq_valid;
    logic [31:0]        sq_root;
    logic [SQ_SW-1:0]   sq_side;
    logic [SIDE_W-1:0]  sq_outer;
    logic [2:0][NW-1:0] sq_nm;
    logic [2:0]         sq_neg;
    logic               sq_nz;

    lav_isqrt #(
        .SIDE_W (SQ_SW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .in_sum    (s5_sum_reg),
        .in_side   ({s5_side_reg, s5_nm_reg, s5_neg_reg, s5_nz_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign {sq_outer, sq_nm, sq_neg, sq_nz} = sq_side;

    // Each component times 2^FRAC_BITS over the length.
    logic               dv_valid;
    logic [2:0][QW-1:0] dv_q;
    logic [DV_SW-1:0]   dv_side;
    logic [SIDE_W-1:0]  dv_outer;
    logic [2:0]         dv_neg;
    logic               dv_nz;

    lav_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (DV_SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_len    (sq_root),
        .in_num    (sq_nm),
        .in_side   ({sq_outer, sq_neg, sq_nz}),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_side  (dv_side)
    );

    assign {dv_outer, dv_neg, dv_nz} = dv_side;

    // Output stage: put the signs back.
    logic               o_valid_reg;
    logic [2:0][CW-1:0] o_vec_reg;
    logic               o_ok_reg;
    logic [SIDE_W-1:0]  o_side_reg;
    logic [2:0][CW-1:0] o_vec_next;
    logic [CW-1:0]      q_ext;

    always_comb
    begin
        q_ext = '0;
        for (int l = 0; l < 3; l++)
        begin
            q_ext         = CW'(dv_q[l]);
            o_vec_next[l] = dv_neg[l] ? (~q_ext + 1'b1) : q_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_vec_reg  <= o_vec_next;
            o_ok_reg   <= dv_nz;
            o_side_reg <= dv_outer;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_vec   = o_vec_reg;
    assign out_ok    = o_ok_reg;
    assign out_side  = o_side_reg;

endmodule

// ===== rtl/lav_ser.sv =====
// Row serializer: holds one finished matrix and sends it out row by row.
// Depends on lav_pkg for the matrix and result types.
module lav_ser
    import lav_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lav_mat_t in_mat,
    output logic     out_valid,
    input  logic     out_ready,
    output lav_res_t out_res
);

    logic       hold_valid_reg;
    logic [1:0] row_reg;
    lav_mat_t   mat_reg;
    logic       last;

    assign last     = (row_reg == LAV_LAST_ROW);
    assign in_ready = !hold_valid_reg || (out_ready && last);

    // Load a new matrix, or step to the next row on each delivered row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            row_reg        <= '0;
        end
        else if (in_valid && in_ready)
        begin
            hold_valid_reg <= 1'b1;
            row_reg        <= '0;
        end
        else if (hold_valid_reg && out_ready)
        begin
            row_reg <= row_reg + 2'd1;
            if (last)
                hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            mat_reg <= in_mat;
    end

    // Present the current row.
    assign out_valid            = hold_valid_reg;
    assign out_res.row_index    = row_reg;
    assign out_res.first_value  = mat_reg.rows[row_reg][0];
    assign out_res.second_value = mat_reg.rows[row_reg][1];
    assign out_res.third_value  = mat_reg.rows[row_reg][2];
    assign out_res.degenerate   = mat_reg.degenerate;
    assign out_res.last_row     = last;

endmodule

// ===== rtl/lookat_view_matrix.sv =====
// Look-at view matrix: camera position, target and up vector in, four rows out.
// Depends on lav_pkg, lav_norm (with lav_isqrt, lav_div) and lav_ser.
//
// Usage:
//   A request on req_valid/req_ready carries pos, target and up in signed
//   Q(32-FRAC_BITS).FRAC_BITS. For each request four results leave on
//   res_valid/res_ready, rows 0 to 3 in order; last_row marks row 3.
//   Rows 0-2 hold the transposed rotation (right, up', forward per column),
//   row 3 the saturated translation. A zero-length vector sets degenerate
//   and zeroes all values.
//   The pipeline takes a request in any cycle in which it is not held; the
//   single result channel sends one row per cycle while res_ready is high,
//   so sustained throughput is bounded by the row serializer, which sends
//   four rows per request.
//   Each normalize holds a 32-stage square root and a FRAC_BITS+1 stage
//   divider, which dominate the latency.
//   Reset clears all valid bits; no request is in flight afterwards.
//   When res_ready is low the serializer keeps its current row. Once the
//   last pipeline stage is full and the serializer cannot take it, the
//   whole pipeline holds and req_ready drops; nothing is lost or sent twice.
module lookat_view_matrix
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = LAV_FRAC_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lav_req_t req_data,
    output logic     res_valid,
    input  logic     res_ready,
    output lav_res_t res_data
);

    localparam int CW   = FRAC_BITS + 2;
    localparam int KW   = 34;
    localparam int WW   = KW + 2;
    localparam int RW   = CW + 1;
    localparam int P1W  = 32 + CW;
    localparam int P3W  = CW + KW;
    localparam int XW   = 2 * CW;
    localparam int P7W  = 32 + RW;
    localparam int TW   = P7W + 3;
    localparam int S1W  = 6 * 32;
    localparam int S2W  = 3 * 32 + 3 * CW + 1;
    localparam logic signed [TW-1:0] SAT_HI = TW'(64'sd2147483647);
    localparam logic signed [TW-1:0] SAT_LO = TW'(-64'sd2147483648);

    logic en;
    logic ser_ready;
    logic t8_valid_reg;

    // The whole pipeline moves unless its last stage is full and blocked.
    assign en        = !t8_valid_reg || ser_ready;
    assign req_ready = en;

    // Stage D: target minus position.
    logic               d_valid_reg;
    logic [2:0][32:0]   d_vec_reg;
    logic [2:0][31:0]   d_pos_reg;
    logic [2:0][31:0]   d_up_reg;
    logic [2:0][31:0]   in_pos;
    logic [2:0][31:0]   in_tgt;
    logic [2:0][31:0]   in_up;

    assign in_pos = {req_data.pos_z, req_data.pos_y, req_data.pos_x};
    assign in_tgt = {req_data.target_z, req_data.target_y, req_data.target_x};
    assign in_up  = {req_data.up_z, req_data.up_y, req_data.up_x};

    // Forward vector.
    logic               f1_valid;
    logic [2:0][CW-1:0] f1_vec;
    logic               f1_ok;
    logic [S1W-1:0]     f1_side;
    logic [2:0][31:0]   f1_pos;
    logic [2:0][31:0]   f1_up;

    lav_norm #(
        .IW        (33),
        .SIDE_W    (S1W),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid_reg),
        .in_vec    (d_vec_reg),
        .in_side   ({d_pos_reg, d_up_reg}),
        .out_valid (f1_valid),
        .out_vec   (f1_vec),
        .out_ok    (f1_ok),
        .out_side  (f1_side)
    );

    assign {f1_pos, f1_up} = f1_side;

    // Stages T1-T4: remove the forward part from up.
    logic                t1_valid_reg;
    logic [2:0][P1W-1:0] t1_prod_reg;
    logic [2:0][CW-1:0]  t1_f_reg;
    logic [2:0][31:0]    t1_pos_reg;
    logic [2:0][31:0]    t1_up_reg;
    logic                t1_ok_reg;
    logic [2:0][P1W-1:0] t1_prod_next;

    logic                t2_valid_reg;
    logic [KW-1:0]       t2_k_reg;
    logic [2:0][CW-1:0]  t2_f_reg;
    logic [2:0][31:0]    t2_pos_reg;
    logic [2:0][31:0]    t2_up_reg;
    logic                t2_ok_reg;
    logic signed [P1W+1:0] dot_sum;
    logic signed [P1W+1:0] dot_shr;

    logic                t3_valid_reg;
    logic [2:0][P3W-1:0] t3_prod_reg;
    logic [2:0][CW-1:0]  t3_f_reg;
    logic [2:0][31:0]    t3_pos_reg;
    logic [2:0][31:0]    t3_up_reg;
    logic                t3_ok_reg;
    logic [2:0][P3W-1:0] t3_prod_next;

    logic                t4_valid_reg;
    logic [2:0][WW-1:0]  t4_w_reg;
    logic [2:0][CW-1:0]  t4_f_reg;
    logic [2:0][31:0]    t4_pos_reg;
    logic                t4_ok_reg;
    logic [2:0][WW-1:0]  t4_w_next;
    logic signed [P3W-1:0] proj_shr;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            t1_prod_next[i] = $signed(f1_up[i]) * $signed(f1_vec[i]);
        dot_sum = $signed(t1_prod_reg[0]) + $signed(t1_prod_reg[1])
                + $signed(t1_prod_reg[2]);
        dot_shr = dot_sum >>> FRAC_BITS;
        for (int i = 0; i < 3; i++)
            t3_prod_next[i] = $signed(t2_f_reg[i]) * $signed(t2_k_reg);
        proj_shr = '0;
        for (int i = 0; i < 3; i++)
        begin
            proj_shr     = $signed(t3_prod_reg[i]) >>> FRAC_BITS;
            t4_w_next[i] = WW'($signed(t3_up_reg[i])) - proj_shr[WW-1:0];
        end
    end

    // Orthogonal up vector.
    logic               u2_valid;
    logic [2:0][CW-1:0] u2_vec;
    logic               u2_ok;
    logic [S2W-1:0]     u2_side;
    logic [2:0][31:0]   u2_pos;
    logic [2:0][CW-1:0] u2_f;
    logic               u2_ok1;

    lav_norm #(
        .IW        (WW),
        .SIDE_W    (S2W),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t4_valid_reg),
        .in_vec    (t4_w_reg),
        .in_side   ({t4_pos_reg, t4_f_reg, t4_ok_reg}),
        .out_valid (u2_valid),
        .out_vec   (u2_vec),
        .out_ok    (u2_ok),
        .out_side  (u2_side)
    );

    assign {u2_pos, u2_f, u2_ok1} = u2_side;

    // Stages T5-T6: right = cross(up', forward).
    logic                t5_valid_reg;
    logic [2:0][XW-1:0]  t5_a_reg;
    logic [2:0][XW-1:0]  t5_b_reg;
    logic [2:0][CW-1:0]  t5_u_reg;
    logic [2:0][CW-1:0]  t5_f_reg;
    logic [2:0][31:0]    t5_pos_reg;
    logic                t5_ok_reg;

    logic                t6_valid_reg;
    logic [2:0][RW-1:0]  t6_r_reg;
    logic [2:0][CW-1:0]  t6_u_reg;
    logic [2:0][CW-1:0]  t6_f_reg;
    logic [2:0][31:0]    t6_pos_reg;
    logic                t6_ok_reg;
    logic [2:0][RW-1:0]  t6_r_next;
    logic signed [XW:0]  cross_diff;
    logic signed [XW:0]  cross_shr;

    always_comb
    begin
        cross_diff = '0;
        cross_shr  = '0;
        for (int i = 0; i < 3; i++)
        begin
            cross_diff   = $signed(t5_a_reg[i]) - $signed(t5_b_reg[i]);
            cross_shr    = cross_diff >>> FRAC_BITS;
            t6_r_next[i] = cross_shr[RW-1:0];
        end
    end

    // Stages T7-T8: translation row and matrix assembly.
    logic                     t7_valid_reg;
    logic [2:0][2:0][P7W-1:0] t7_prod_reg;
    logic [2:0][RW-1:0]       t7_r_reg;
    logic [2:0][CW-1:0]       t7_u_reg;
    logic [2:0][CW-1:0]       t7_f_reg;
    logic                     t7_ok_reg;
    logic [2:0][2:0][P7W-1:0] t7_prod_next;

    lav_mat_t                 t8_mat_reg;
    lav_mat_t                 t8_mat_next;
    logic signed [P7W+1:0]    tr_sum;
    logic signed [P7W+1:0]    tr_shr;
    logic signed [TW-1:0]     tr_neg;
    logic [31:0]              tr_val;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t7_prod_next[0][i] = $signed(t6_pos_reg[i]) * $signed(t6_r_reg[i]);
            t7_prod_next[1][i] = $signed(t6_pos_reg[i]) * $signed(t6_u_reg[i]);
            t7_prod_next[2][i] = $signed(t6_pos_reg[i]) * $signed(t6_f_reg[i]);
        end
    end

    always_comb
    begin
        t8_mat_next = '0;
        tr_sum      = '0;
        tr_shr      = '0;
        tr_neg      = '0;
        tr_val      = '0;
        for (int i = 0; i < 3; i++)
        begin
            t8_mat_next.rows[i][0] = 32'($signed(t7_r_reg[i]));
            t8_mat_next.rows[i][1] = 32'($signed(t7_u_reg[i]));
            t8_mat_next.rows[i][2] = 32'($signed(t7_f_reg[i]));
        end
        for (int c = 0; c < 3; c++)
        begin
            tr_sum = $signed(t7_prod_reg[c][0]) + $signed(t7_prod_reg[c][1])
                   + $signed(t7_prod_reg[c][2]);
            tr_shr = tr_sum >>> FRAC_BITS;
            tr_neg = -tr_shr;
            if (tr_neg > SAT_HI)
                tr_val = SAT_HI[31:0];
            else if (tr_neg < SAT_LO)
                tr_val = SAT_LO[31:0];
            else
                tr_val = tr_neg[31:0];
            t8_mat_next.rows[LAV_LAST_ROW][c] = tr_val;
        end
        if (!t7_ok_reg)
            t8_mat_next.rows = '0;
        t8_mat_next.degenerate = !t7_ok_reg;
    end

    // Valid bits of the glue stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg  <= 1'b0;
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            t5_valid_reg <= 1'b0;
            t6_valid_reg <= 1'b0;
            t7_valid_reg <= 1'b0;
            t8_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg  <= req_valid;
            t1_valid_reg <= f1_valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= t3_valid_reg;
            t5_valid_reg <= u2_valid;
            t6_valid_reg <= t5_valid_reg;
            t7_valid_reg <= t6_valid_reg;
            t8_valid_reg <= t7_valid_reg;
        end
    end

    // Payload of the glue stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                d_vec_reg[i] <= 33'($signed(in_tgt[i])) - 33'($signed(in_pos[i]));
            d_pos_reg    <= in_pos;
            d_up_reg     <= in_up;

            t1_prod_reg  <= t1_prod_next;
            t1_f_reg     <= f1_vec;
            t1_pos_reg   <= f1_pos;
            t1_up_reg    <= f1_up;
            t1_ok_reg    <= f1_ok;

            t2_k_reg     <= dot_shr[KW-1:0];
            t2_f_reg     <= t1_f_reg;
            t2_pos_reg   <= t1_pos_reg;
            t2_up_reg    <= t1_up_reg;
            t2_ok_reg    <= t1_ok_reg;

            t3_prod_reg  <= t3_prod_next;
            t3_f_reg     <= t2_f_reg;
            t3_pos_reg   <= t2_pos_reg;
            t3_up_reg    <= t2_up_reg;
            t3_ok_reg    <= t2_ok_reg;

            t4_w_reg     <= t4_w_next;
            t4_f_reg     <= t3_f_reg;
            t4_pos_reg   <= t3_pos_reg;
            t4_ok_reg    <= t3_ok_reg;

            t5_a_reg[0]  <= $signed(u2_vec[1]) * $signed(u2_f[2]);
            t5_b_reg[0]  <= $signed(u2_vec[2]) * $signed(u2_f[1]);
            t5_a_reg[1]  <= $signed(u2_vec[2]) * $signed(u2_f[0]);
            t5_b_reg[1]  <= $signed(u2_vec[0]) * $signed(u2_f[2]);
            t5_a_reg[2]  <= $signed(u2_vec[0]) * $signed(u2_f[1]);
            t5_b_reg[2]  <= $signed(u2_vec[1]) * $signed(u2_f[0]);
            t5_u_reg     <= u2_vec;
            t5_f_reg     <= u2_f;
            t5_pos_reg   <= u2_pos;
            t5_ok_reg    <= u2_ok && u2_ok1;

            t6_r_reg     <= t6_r_next;
            t6_u_reg     <= t5_u_reg;
            t6_f_reg     <= t5_f_reg;
            t6_pos_reg   <= t5_pos_reg;
            t6_ok_reg    <= t5_ok_reg;

            t7_prod_reg  <= t7_prod_next;
            t7_r_reg     <= t6_r_reg;
            t7_u_reg     <= t6_u_reg;
            t7_f_reg     <= t6_f_reg;
            t7_ok_reg    <= t6_ok_reg;

            t8_mat_reg   <= t8_mat_next;
        end
    end

    // Row serializer on the result channel.
    lav_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t8_valid_reg),
        .in_ready  (ser_ready),
        .in_mat    (t8_mat_reg),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_res   (res_data)
    );

endmodule
